@@ design/pnc_pkg.sv @@
// Package for the nearest palette color block: widths, codes, FSM state type
// and the structs passed between the sequencer and the distance unit.
// No dependencies.
package pnc_pkg;

  localparam int IDX_W   = 8;
  localparam int DIST_W  = 18;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int SQ_W    = 2 * CHAN_W;

  localparam logic [DIST_W-1:0] NO_MATCH_DIST = 18'h30000;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } pnc_state_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
  } pnc_tag_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } pnc_best_t;

endpackage

@@ design/pnc_ifs.sv @@
// Valid/ready channel interfaces for the search request and result words.
// Depends on pnc_pkg.
interface pnc_in_if
  import pnc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [IDX_W-1:0]   start_index;
  logic [IDX_W-1:0]   range_last;
  logic [COLOR_W-1:0] color;

  modport source (output valid, output mode, output start_index, output range_last,
                  output color, input ready);
  modport sink   (input valid, input mode, input start_index, input range_last,
                  input color, output ready);
endinterface

interface pnc_out_if
  import pnc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  nearest_index;
  logic [DIST_W-1:0] best_distance;

  modport source (output valid, output nearest_index, output best_distance, input ready);
  modport sink   (input valid, input nearest_index, input best_distance, output ready);
endinterface

@@ design/pnc_palette_mem.sv @@
// Palette memory: one write port and one read port with registered read data.
// Depends on pnc_pkg.
module pnc_palette_mem
  import pnc_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [COLOR_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [COLOR_W-1:0] rd_data
);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/pnc_dist_unit.sv @@
// Shared distance unit: absolute channel differences, squares, then sum and
// running minimum, one palette entry per cycle. Depends on pnc_pkg.
module pnc_dist_unit
  import pnc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  logic [COLOR_W-1:0] ref_color,
  input  logic [COLOR_W-1:0] entry_color,
  input  pnc_tag_t           tag_in,
  output logic               busy,
  output pnc_best_t          best
);

  logic [CHAN_W-1:0] diff_nxt [3];
  logic [CHAN_W-1:0] diff_r   [3];
  logic [SQ_W-1:0]   sq_r     [3];
  pnc_tag_t          s1_tag_r;
  pnc_tag_t          s2_tag_r;
  pnc_best_t         best_r;
  logic [DIST_W-1:0] sum;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      a = ref_color[c*CHAN_W +: CHAN_W];
      b = entry_color[c*CHAN_W +: CHAN_W];
      diff_nxt[c] = (a > b) ? (a - b) : (b - a);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      diff_r[c] <= diff_nxt[c];
      sq_r[c]   <= SQ_W'(diff_r[c]) * SQ_W'(diff_r[c]);
    end
    s1_tag_r.index <= tag_in.index;
    s2_tag_r.index <= s1_tag_r.index;
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
      s2_tag_r.valid <= 1'b0;
    end else begin
      s1_tag_r.valid <= tag_in.valid;
      s2_tag_r.valid <= s1_tag_r.valid;
    end
  end

  assign sum = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);

  // Strict compare keeps the lowest index on ties since entries arrive in order.
  always_ff @(posedge clk) begin
    if (clear) begin
      best_r.index    <= '0;
      best_r.distance <= NO_MATCH_DIST;
    end else if (s2_tag_r.valid && (sum < best_r.distance)) begin
      best_r.index    <= s2_tag_r.index;
      best_r.distance <= sum;
    end
  end

  assign busy = s1_tag_r.valid || s2_tag_r.valid;
  assign best = best_r;

endmodule

@@ design/palette_nearest_color.sv @@
// Channel    | Dir | Word
// in_chan    | in  | mode, start_index, range_last, color
// out_chan   | out | nearest_index, best_distance (one per search)
// A write goes to the palette when accepted. A search reads its entries in order
// through the single palette read port, one entry per cycle, then drains the pipeline.
// An empty range skips the scan and goes from idle straight to the finish state.
// Input is taken only when the sequencer is idle; a waiting result does not block
// a new word, only the end of the next search. Reset is synchronous, active low.
// Depends on pnc_pkg, pnc_ifs, pnc_palette_mem and pnc_dist_unit.
module palette_nearest_color
  import pnc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic  clk,
  input  logic  rst_n,
  pnc_in_if.sink    in_chan,
  pnc_out_if.source out_chan
);

  localparam int               AW       = $clog2(PALETTE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(PALETTE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_DEPTH - 1);

  pnc_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   last_r;
  logic [COLOR_W-1:0] color_r;
  pnc_tag_t           rd_tag_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;

  logic               in_acc;
  logic               out_free;
  logic               wr_en;
  logic [IDX_W-1:0]   last_eff;
  logic               empty;
  logic               load_out;
  logic [COLOR_W-1:0] rd_data;
  logic               busy;
  pnc_best_t          best;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign wr_en         = in_acc && (in_chan.mode == MODE_WRITE) &&
                         ({1'b0, in_chan.start_index} < DEPTH_X);
  assign last_eff      = (in_chan.range_last < LAST_IDX) ? in_chan.range_last : LAST_IDX;
  assign empty         = in_chan.start_index > last_eff;
  assign load_out      = (state_r == ST_FINISH) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_chan.mode == MODE_SEARCH)) begin
          state_nxt = empty ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_tag_r.valid && !busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_tag_r.index <= idx_r;
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rd_tag_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rd_tag_r.valid <= (state_r == ST_SCAN);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r   <= in_chan.start_index;
      last_r  <= last_eff;
      color_r <= in_chan.color;
    end else if (state_r == ST_SCAN) begin
      idx_r <= idx_r + 1'b1;
    end
    if (load_out) begin
      out_idx_r  <= best.index;
      out_dist_r <= best.distance;
    end
  end

  pnc_palette_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_chan.start_index[AW-1:0]),
    .wr_data (in_chan.color),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  pnc_dist_unit u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (in_acc),
    .ref_color   (color_r),
    .entry_color (rd_data),
    .tag_in      (rd_tag_r),
    .busy        (busy),
    .best        (best)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.nearest_index = out_idx_r;
  assign out_chan.best_distance = out_dist_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= last_r) && ({1'b0, idx_r} < DEPTH_X))
    else $error("scan index left the search range");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (best.distance <= NO_MATCH_DIST))
    else $error("best distance above the no-match value");

  a_no_match_index: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (best.distance == NO_MATCH_DIST)) |-> (best.index == '0))
    else $error("no-match result with nonzero index");

  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (!busy && !rd_tag_r.valid))
    else $error("result taken while distance pipeline still busy");

endmodule
